[rtl/shaker_sort_descending_assert.svh]
// assertion macros for the shaker sort block
`ifndef SHAKER_SORT_DESCENDING_ASSERT_SVH
`define SHAKER_SORT_DESCENDING_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SSD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ssd_pkg.sv]
// shared types and constants for the descending shaker sort block
package ssd_pkg;

  localparam int SSD_MAX_RECORDS = 64;

  typedef struct packed {
    logic [15:0] product_tag;
    logic [7:0]  shop_id;
    logic [19:0] quantity;
  } rec_t;

  typedef struct packed {
    logic [19:0] quantity;
    logic [7:0]  shop_id;
    logic [15:0] product_tag;
    logic        last_record;
  } in_item_t;

  typedef struct packed {
    logic [19:0] quantity_out;
    logic [7:0]  shop_id_out;
    logic [15:0] product_tag_out;
    logic        last_out;
    logic        overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_F_PRIME,
    ST_F_HEAD,
    ST_F_RUN,
    ST_F_TAIL,
    ST_B_PRIME,
    ST_B_HEAD,
    ST_B_RUN,
    ST_B_TAIL,
    ST_E_RD,
    ST_E_LD
  } ssd_state_t;

endpackage

[rtl/shaker_sort_descending.sv]
// descending cocktail shaker sort of production records over one record memory
//
// in_valid/in_stall/in_item: one record per item, stored in arrival order, one
//   per cycle unless stalled. records beyond MAX_RECORDS are dropped and the set
//   is flagged. an item with last_record set closes the set; in_stall then stays
//   high until every record of the set has been handed to the output register.
// sort: forward and backward passes over a narrowing window, one compare-swap
//   per cycle, plus prime, head and tail steps per pass; stops after a round
//   with no swap or once the window has closed.
// emission: out_valid/out_stall/out_item, records read one at a time, largest
//   quantity first, equal quantities in arrival order, last_out on the final
//   record, overflow on every record of a set that lost records.
// a stalled result waits in the output register; the next set is loaded
//   meanwhile, and its emission waits for the register to free up.
// reset clears the record count, the overflow flag and the output valid; the
//   memory needs no clearing pass since only written entries are ever read.
`include "shaker_sort_descending_assert.svh"

module shaker_sort_descending #(
  parameter int MAX_RECORDS = ssd_pkg::SSD_MAX_RECORDS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ssd_pkg::in_item_t    in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ssd_pkg::out_item_t   out_item
);
  import ssd_pkg::*;

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_RECORDS);

  ssd_state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [AW-1:0] lo_r, lo_nxt;
  logic [AW-1:0] hi_r, hi_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic          moved_r, moved_nxt;
  rec_t          cur_r, cur_nxt;
  out_item_t     out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  rec_t          mem [MAX_RECORDS];
  rec_t          rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  rec_t          wr_data;

  logic          in_acc;
  logic          out_free;
  logic          out_load;
  logic          fwd_swap;
  logic          bwd_swap;
  logic [AW-1:0] last_idx;
  rec_t          new_rec;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign last_idx = AW'(count_r - CW'(1));
  // forward: carried record sits at i, memory record at i+1
  assign fwd_swap = cur_r.quantity < rd_data_r.quantity;
  // backward: memory record sits at i-1, carried record at i
  assign bwd_swap = rd_data_r.quantity < cur_r.quantity;

  assign new_rec.product_tag = in_item.product_tag;
  assign new_rec.shop_id     = in_item.shop_id;
  assign new_rec.quantity    = in_item.quantity;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc && in_item.last_record) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (count_r < CW'(2)) begin
          state_nxt = ST_E_RD;
        end else begin
          state_nxt = ST_F_PRIME;
        end
      end
      ST_F_PRIME: state_nxt = ST_F_HEAD;
      ST_F_HEAD:  state_nxt = ST_F_RUN;
      ST_F_RUN: begin
        if (ptr_r + AW'(1) == hi_r) begin
          state_nxt = ST_F_TAIL;
        end
      end
      ST_F_TAIL: begin
        if (hi_r - AW'(1) > lo_r) begin
          state_nxt = ST_B_PRIME;
        end else begin
          state_nxt = ST_E_RD;
        end
      end
      ST_B_PRIME: state_nxt = ST_B_HEAD;
      ST_B_HEAD:  state_nxt = ST_B_RUN;
      ST_B_RUN: begin
        if (ptr_r - AW'(1) == lo_r) begin
          state_nxt = ST_B_TAIL;
        end
      end
      ST_B_TAIL: begin
        if ((lo_r + AW'(1) < hi_r) && moved_r) begin
          state_nxt = ST_F_PRIME;
        end else begin
          state_nxt = ST_E_RD;
        end
      end
      ST_E_RD: state_nxt = ST_E_LD;
      ST_E_LD: begin
        if (out_free) begin
          if (ptr_r == last_idx) begin
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_E_RD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // memory port control and handshake outputs
  always_comb begin
    in_stall = (state_r != ST_LOAD);
    rd_addr  = ptr_r;
    wr_en    = 1'b0;
    wr_addr  = ptr_r;
    wr_data  = cur_r;
    out_load = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        wr_en   = in_acc && (count_r < FULL);
        wr_addr = count_r[AW-1:0];
        wr_data = new_rec;
      end
      ST_START: begin
        rd_addr = ptr_r;
      end
      ST_F_PRIME: rd_addr = lo_r;
      ST_F_HEAD:  rd_addr = lo_r + AW'(1);
      ST_F_RUN: begin
        rd_addr = ptr_r + AW'(2);
        wr_en   = 1'b1;
        wr_data = fwd_swap ? rd_data_r : cur_r;
      end
      ST_F_TAIL: begin
        wr_en   = 1'b1;
        wr_addr = hi_r;
      end
      ST_B_PRIME: rd_addr = hi_r;
      ST_B_HEAD:  rd_addr = hi_r - AW'(1);
      ST_B_RUN: begin
        rd_addr = ptr_r - AW'(2);
        wr_en   = 1'b1;
        wr_data = bwd_swap ? rd_data_r : cur_r;
      end
      ST_B_TAIL: begin
        wr_en   = 1'b1;
        wr_addr = lo_r;
      end
      ST_E_RD: rd_addr = ptr_r;
      ST_E_LD: begin
        rd_addr  = ptr_r;
        out_load = out_free;
      end
      default: rd_addr = ptr_r;
    endcase
  end

  // datapath next values
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    ptr_nxt   = ptr_r;
    moved_nxt = moved_r;
    cur_nxt   = cur_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (count_r < FULL) begin
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      ST_START: begin
        lo_nxt    = '0;
        hi_nxt    = last_idx;
        ptr_nxt   = '0;
        moved_nxt = 1'b0;
      end
      ST_F_HEAD: begin
        cur_nxt   = rd_data_r;
        ptr_nxt   = lo_r;
        moved_nxt = 1'b0;
      end
      ST_F_RUN: begin
        if (fwd_swap) begin
          moved_nxt = 1'b1;
        end else begin
          cur_nxt = rd_data_r;
        end
        ptr_nxt = ptr_r + AW'(1);
      end
      ST_F_TAIL: begin
        hi_nxt  = hi_r - AW'(1);
        ptr_nxt = '0;
      end
      ST_B_HEAD: begin
        cur_nxt = rd_data_r;
        ptr_nxt = hi_r;
      end
      ST_B_RUN: begin
        if (bwd_swap) begin
          moved_nxt = 1'b1;
        end else begin
          cur_nxt = rd_data_r;
        end
        ptr_nxt = ptr_r - AW'(1);
      end
      ST_B_TAIL: begin
        lo_nxt  = lo_r + AW'(1);
        ptr_nxt = '0;
      end
      ST_E_LD: begin
        if (out_free) begin
          if (ptr_r == last_idx) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end else begin
            ptr_nxt = ptr_r + AW'(1);
          end
        end
      end
      default: begin
        cur_nxt = cur_r;
      end
    endcase
  end

  // output register
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_nxt.quantity_out    = rd_data_r.quantity;
      out_nxt.shop_id_out     = rd_data_r.shop_id;
      out_nxt.product_tag_out = rd_data_r.product_tag;
      out_nxt.last_out        = (ptr_r == last_idx);
      out_nxt.overflow        = ovf_r;
      out_valid_nxt           = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    ptr_r   <= ptr_nxt;
    moved_r <= moved_nxt;
    cur_r   <= cur_nxt;
    out_r   <= out_nxt;
  end

  // record memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  `SSD_ASSERT_IMPLY(a_sort_wr_window, (wr_en && state_r != ST_LOAD), ((wr_addr >= lo_r) && (wr_addr <= hi_r)), "sort write outside the active window")
  `SSD_ASSERT_IMPLY(a_busy_has_records, (state_r != ST_LOAD), (count_r != '0), "sort or emission running on an empty set")
  `SSD_ASSERT_NEXT(a_set_cleared, (out_load && ptr_r == last_idx), ((count_r == '0) && !ovf_r), "set not cleared after its final record")

endmodule
